// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// shared constants, types and phase codes for the speed profile core
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int DIST_WIDTH_DEF  = 24;
   localparam int SPEED_WIDTH_DEF = 20;

   localparam logic [1:0] PHASE_ACCEL  = 2'd0;
   localparam logic [1:0] PHASE_CRUISE = 2'd1;
   localparam logic [1:0] PHASE_DECEL  = 2'd2;

   localparam logic CSR_PEAK_SPEED = 1'b0;
   localparam logic CSR_ACCEL_RATE = 1'b1;

   // per-transaction side data that rides along the root chain
   typedef struct packed {
      logic [1:0] phase;
      logic       triangular;
      logic       use_peak;
   } tag_type;

endpackage

// ===== rtl/tsp_root_cell.sv =====
// ----------------------------------------------------------------------------
// tsp_root_cell
// one digit step of a restoring integer square root
// ----------------------------------------------------------------------------
module tsp_root_cell #(
   parameter int RW = 64,
   parameter int QW = 32,
   parameter int SW = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 stall,
   input  logic                 valid_in,
   input  logic [RW-1:0]        rad_in,
   input  logic [QW-1:0]        root_in,
   input  logic [QW+1:0]        rem_in,
   input  logic [SW-1:0]        peak_in,
   input  tsp_pkg::tag_type     tag_in,
   output logic                 valid_out,
   output logic [RW-1:0]        rad_out,
   output logic [QW-1:0]        root_out,
   output logic [QW+1:0]        rem_out,
   output logic [SW-1:0]        peak_out,
   output tsp_pkg::tag_type     tag_out
);

   logic                valid_ff;
   logic [RW-1:0]       rad_ff, rad_in_w;
   logic [QW-1:0]       root_ff, root_in_w;
   logic [QW+1:0]       rem_ff, rem_in_w, trial, cur;
   logic [SW-1:0]       peak_ff;
   tsp_pkg::tag_type    tag_ff;

   always_comb begin
      // bring down the next two radicand bits
      cur   = {rem_in[QW-1:0], rad_in[RW-1 -: 2]};
      trial = {root_in, 2'b01};
      if (cur >= trial) begin
         rem_in_w  = cur - trial;
         root_in_w = {root_in[QW-2:0], 1'b1};
      end else begin
         rem_in_w  = cur;
         root_in_w = {root_in[QW-2:0], 1'b0};
      end
      rad_in_w = {rad_in[RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         rad_ff  <= rad_in_w;
         root_ff <= root_in_w;
         rem_ff  <= rem_in_w;
         peak_ff <= peak_in;
         tag_ff  <= tag_in;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign root_out  = root_ff;
   assign rem_out   = rem_ff;
   assign peak_out  = peak_ff;
   assign tag_out   = tag_ff;

endmodule

// ===== rtl/tsp_front.sv =====
// ----------------------------------------------------------------------------
// tsp_front
// products, phase decision and radicand selection, two register stages
// ----------------------------------------------------------------------------
module tsp_front #(
   parameter int DW = 24,
   parameter int SW = 20,
   parameter int RW = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              stall,
   input  logic              valid_in,
   input  logic [DW-1:0]     path_length,
   input  logic [DW-1:0]     remaining,
   input  logic [SW-1:0]     peak_speed,
   input  logic [SW-1:0]     accel_rate,
   output logic              valid_out,
   output logic [RW-1:0]     rad_out,
   output logic [SW-1:0]     peak_out,
   output tsp_pkg::tag_type  tag_out
);

   localparam int PW = DW + SW;

   // stage 1: products
   logic              v1_ff;
   logic [PW-1:0]     tot_a_ff, trav_a_ff, rem_a_ff;
   logic [2*SW-1:0]   vsq_ff;
   logic [DW-1:0]     trav_ff, total_ff;
   logic [SW-1:0]     peak1_ff;
   logic [DW-1:0]     trav_w;

   assign trav_w = (remaining > path_length) ? '0 : path_length - remaining;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (!stall) begin
         v1_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         tot_a_ff  <= PW'(path_length) * PW'(accel_rate);
         trav_a_ff <= PW'(trav_w) * PW'(accel_rate);
         rem_a_ff  <= PW'(remaining) * PW'(accel_rate);
         vsq_ff    <= (2*SW)'(peak_speed) * (2*SW)'(peak_speed);
         trav_ff   <= trav_w;
         total_ff  <= path_length;
         peak1_ff  <= peak_speed;
      end
   end

   // stage 2: decision
   localparam int CW = (PW > 2*SW ? PW : 2*SW) + 2;
   logic [CW-1:0]    tot_c, trav2_c, rem2_c, vsq_c;
   logic             tri_w, acc_w, dec_w;
   logic [PW-1:0]    prod_w;
   tsp_pkg::tag_type tag_w;
   logic             v2_ff;
   logic [RW-1:0]    rad_ff;
   logic [SW-1:0]    peak2_ff;
   tsp_pkg::tag_type tag_ff;

   always_comb begin
      tot_c   = CW'(tot_a_ff);
      trav2_c = CW'(trav_a_ff) << 1;
      rem2_c  = CW'(rem_a_ff) << 1;
      vsq_c   = CW'(vsq_ff);
      tri_w   = !(tot_c > vsq_c);
      if (!tri_w) begin
         acc_w = trav2_c < vsq_c;
         dec_w = !acc_w && (rem2_c < vsq_c);
      end else begin
         acc_w = ({1'b0, trav_ff} << 1) < {1'b0, total_ff};
         dec_w = !acc_w;
      end
      prod_w = acc_w ? trav_a_ff : rem_a_ff;
      tag_w.triangular = tri_w;
      tag_w.use_peak   = !acc_w && !dec_w;
      tag_w.phase      = acc_w ? tsp_pkg::PHASE_ACCEL :
                         (dec_w ? tsp_pkg::PHASE_DECEL : tsp_pkg::PHASE_CRUISE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (!stall) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         rad_ff   <= RW'({prod_w, 1'b0});
         peak2_ff <= peak1_ff;
         tag_ff   <= tag_w;
      end
   end

   assign valid_out = v2_ff;
   assign rad_out   = rad_ff;
   assign peak_out  = peak2_ff;
   assign tag_out   = tag_ff;

endmodule

// ===== rtl/trapezoid_speed_profile_core.sv =====
// ----------------------------------------------------------------------------
// trapezoid_speed_profile_core
// target speed of a one-dimensional trapezoidal or triangular profile
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while not stalled and passes it through two
// front stages (products, then phase decision), one cell per root bit of the
// square root chain (DIST_WIDTH+SPEED_WIDTH+1 halved, rounded up), and one
// output register. A stall on the result side freezes the whole chain. The
// ramp speed floor(sqrt(2*a*d)) is computed exactly by a chain of restoring
// square root cells, each fixing one result bit, and clipped at peak_speed;
// in the cruise phase the result is peak_speed itself. Registers may be
// written only while no transaction is in flight.
module trapezoid_speed_profile_core #(
   parameter int DIST_WIDTH  = tsp_pkg::DIST_WIDTH_DEF,
   parameter int SPEED_WIDTH = tsp_pkg::SPEED_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DIST_WIDTH-1:0]  req_path_length,
   input  logic [DIST_WIDTH-1:0]  req_remaining,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SPEED_WIDTH-1:0] rsp_speed_out,
   output logic [1:0]             rsp_phase,
   output logic                   rsp_triangular,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [SPEED_WIDTH-1:0] csr_data
);

   // radicand 2*a*d is at most DW+SW+1 bits; pad to even
   localparam int NB = (DIST_WIDTH + SPEED_WIDTH + 2) / 2;
   localparam int RW = 2 * NB;
   localparam int QW = NB;
   // common width for the root against peak compare
   localparam int MW = (QW > SPEED_WIDTH) ? QW : SPEED_WIDTH;

   logic [SPEED_WIDTH-1:0] peak_ff, accel_ff;
   logic                   stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= SPEED_WIDTH'(65536);
         accel_ff <= SPEED_WIDTH'(65536);
      end else if (csr_write) begin
         case (csr_index)
            tsp_pkg::CSR_PEAK_SPEED: peak_ff  <= csr_data;
            tsp_pkg::CSR_ACCEL_RATE: accel_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // output register holds while stalled; whole chain moves together
   assign stall     = rsp_valid && rsp_stall;
   assign req_stall = stall;

   logic                   fv;
   logic [RW-1:0]          frad;
   logic [SPEED_WIDTH-1:0] fpeak;
   tsp_pkg::tag_type       ftag;

   tsp_front #(.DW(DIST_WIDTH), .SW(SPEED_WIDTH), .RW(RW)) u_front (
      .clock(clock), .reset(reset), .stall(stall), .valid_in(req_valid),
      .path_length(req_path_length), .remaining(req_remaining),
      .peak_speed(peak_ff), .accel_rate(accel_ff),
      .valid_out(fv), .rad_out(frad), .peak_out(fpeak), .tag_out(ftag)
   );

   // chain of root cells
   logic                   cv    [NB+1];
   logic [RW-1:0]          crad  [NB+1];
   logic [QW-1:0]          croot [NB+1];
   logic [QW+1:0]          crem  [NB+1];
   logic [SPEED_WIDTH-1:0] cpeak [NB+1];
   tsp_pkg::tag_type       ctag  [NB+1];

   assign cv[0]    = fv;
   assign crad[0]  = frad;
   assign croot[0] = '0;
   assign crem[0]  = '0;
   assign cpeak[0] = fpeak;
   assign ctag[0]  = ftag;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      tsp_root_cell #(.RW(RW), .QW(QW), .SW(SPEED_WIDTH)) u_cell (
         .clock(clock), .reset(reset), .stall(stall),
         .valid_in(cv[i]), .rad_in(crad[i]), .root_in(croot[i]),
         .rem_in(crem[i]), .peak_in(cpeak[i]), .tag_in(ctag[i]),
         .valid_out(cv[i+1]), .rad_out(crad[i+1]), .root_out(croot[i+1]),
         .rem_out(crem[i+1]), .peak_out(cpeak[i+1]), .tag_out(ctag[i+1])
      );
   end

   // final clip and output register
   logic                   out_v_ff;
   logic [SPEED_WIDTH-1:0] speed_ff, speed_in;
   logic [1:0]             phase_ff;
   logic                   tri_ff;
   logic [MW-1:0]          peak_q, root_q;

   always_comb begin
      peak_q = MW'(cpeak[NB]);
      root_q = MW'(croot[NB]);
      if (ctag[NB].use_peak || root_q >= peak_q) begin
         speed_in = cpeak[NB];
      end else begin
         speed_in = root_q[SPEED_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (!stall) begin
         out_v_ff <= cv[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         speed_ff <= speed_in;
         phase_ff <= ctag[NB].phase;
         tri_ff   <= ctag[NB].triangular;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_speed_out  = speed_ff;
   assign rsp_phase      = phase_ff;
   assign rsp_triangular = tri_ff;

endmodule
